FILE: rtl/gmrc_pkg.sv
// Shared widths, codes, defaults and types of the gimbal mode and rate command block.
`default_nettype none

package gmrc_pkg;

    // field widths
    localparam int unsigned SW_W         = 2;
    localparam int unsigned STICK_W      = 11;
    localparam int unsigned MOUSE_W      = 16;
    localparam int unsigned ANGLE_W      = 16;
    localparam int unsigned GAIN_W       = 16;
    localparam int unsigned DB_W         = 10;
    localparam int unsigned TOL_W        = 15;
    localparam int unsigned MODE_W       = 3;
    localparam int unsigned INC_W        = 16;

    // arithmetic widths
    localparam int unsigned ERR_W        = ANGLE_W + 1;
    localparam int unsigned PROD_W       = 33;
    localparam int unsigned SUM_W        = PROD_W + 1;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned QUOT_W       = SUM_W - FRAC_W;

    // state counters
    localparam int unsigned INIT_CNT_W   = 13;
    localparam int unsigned SETTLE_CNT_W = 8;

    // stream widths
    localparam int unsigned S_TDATA_W    = 96;
    localparam int unsigned M_TDATA_W    = 40;

    // register port
    localparam int unsigned CFG_ADDR_W   = 5;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned REG_IDX_W    = 3;

    // gimbal modes
    localparam logic [MODE_W-1:0] MODE_RELAX   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INIT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GYRO    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENCODER = 3'd4;

    // switch positions
    localparam logic [SW_W-1:0] SW_UP   = 2'd1;
    localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
    localparam logic [SW_W-1:0] SW_MID  = 2'd3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_STICK_DEADBAND    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_YAW_STICK_GAIN    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_STICK_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_YAW_MOUSE_GAIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_MOUSE_GAIN  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HOME_TOLERANCE    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_YAW_RETURN_GAIN   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PITCH_RETURN_GAIN = 3'd7;

    // register reset values
    localparam logic [DB_W-1:0]   RST_STICK_DEADBAND = 10'd10;
    localparam logic [GAIN_W-1:0] RST_STICK_GAIN     = 16'd16;
    localparam logic [GAIN_W-1:0] RST_MOUSE_GAIN     = 16'd64;
    localparam logic [TOL_W-1:0]  RST_HOME_TOLERANCE = 15'd410;
    localparam logic [GAIN_W-1:0] RST_RETURN_GAIN    = 16'd328;

    // parameter defaults
    localparam int DEF_INIT_TIMEOUT_TICKS = 6000;
    localparam int DEF_SETTLE_TICKS       = 200;
    localparam int DEF_HOME_YAW           = 0;
    localparam int DEF_HOME_PITCH         = 0;

    typedef struct packed {
        logic [DB_W-1:0]   stick_deadband;
        logic [GAIN_W-1:0] yaw_stick_gain;
        logic [GAIN_W-1:0] pitch_stick_gain;
        logic [GAIN_W-1:0] yaw_mouse_gain;
        logic [GAIN_W-1:0] pitch_mouse_gain;
        logic [TOL_W-1:0]  home_tolerance;
        logic [GAIN_W-1:0] yaw_return_gain;
        logic [GAIN_W-1:0] pitch_return_gain;
    } gmrc_cfg_t;

    // command selection for the current transaction, after the mode update
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              manual;      // gyro or encoder: stick and mouse
        logic              homing;      // init: proportional return
        logic              yaw_homing;  // init: yaw axis returns as well
    } gmrc_sel_t;

endpackage

`default_nettype wire

FILE: rtl/gmrc_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module gmrc_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gmrc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [gmrc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [gmrc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output gmrc_pkg::gmrc_cfg_t                   cfg
);

    localparam int DW = gmrc_pkg::CFG_DATA_W;

    gmrc_pkg::gmrc_cfg_t            cfg_reg;
    gmrc_pkg::gmrc_cfg_t            cfg_next;
    logic [gmrc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gmrc_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                gmrc_pkg::REG_STICK_DEADBAND:
                    cfg_next.stick_deadband = pwdata[gmrc_pkg::DB_W-1:0];
                gmrc_pkg::REG_YAW_STICK_GAIN:
                    cfg_next.yaw_stick_gain = pwdata[gmrc_pkg::GAIN_W-1:0];
                gmrc_pkg::REG_PITCH_STICK_GAIN:
                    cfg_next.pitch_stick_gain = pwdata[gmrc_pkg::GAIN_W-1:0];
                gmrc_pkg::REG_YAW_MOUSE_GAIN:
                    cfg_next.yaw_mouse_gain = pwdata[gmrc_pkg::GAIN_W-1:0];
                gmrc_pkg::REG_PITCH_MOUSE_GAIN:
                    cfg_next.pitch_mouse_gain = pwdata[gmrc_pkg::GAIN_W-1:0];
                gmrc_pkg::REG_HOME_TOLERANCE:
                    cfg_next.home_tolerance = pwdata[gmrc_pkg::TOL_W-1:0];
                gmrc_pkg::REG_YAW_RETURN_GAIN:
                    cfg_next.yaw_return_gain = pwdata[gmrc_pkg::GAIN_W-1:0];
                gmrc_pkg::REG_PITCH_RETURN_GAIN:
                    cfg_next.pitch_return_gain = pwdata[gmrc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stick_deadband    <= gmrc_pkg::RST_STICK_DEADBAND;
            cfg_reg.yaw_stick_gain    <= gmrc_pkg::RST_STICK_GAIN;
            cfg_reg.pitch_stick_gain  <= gmrc_pkg::RST_STICK_GAIN;
            cfg_reg.yaw_mouse_gain    <= gmrc_pkg::RST_MOUSE_GAIN;
            cfg_reg.pitch_mouse_gain  <= gmrc_pkg::RST_MOUSE_GAIN;
            cfg_reg.home_tolerance    <= gmrc_pkg::RST_HOME_TOLERANCE;
            cfg_reg.yaw_return_gain   <= gmrc_pkg::RST_RETURN_GAIN;
            cfg_reg.pitch_return_gain <= gmrc_pkg::RST_RETURN_GAIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            gmrc_pkg::REG_STICK_DEADBAND:    prdata = DW'(cfg_reg.stick_deadband);
            gmrc_pkg::REG_YAW_STICK_GAIN:    prdata = DW'(cfg_reg.yaw_stick_gain);
            gmrc_pkg::REG_PITCH_STICK_GAIN:  prdata = DW'(cfg_reg.pitch_stick_gain);
            gmrc_pkg::REG_YAW_MOUSE_GAIN:    prdata = DW'(cfg_reg.yaw_mouse_gain);
            gmrc_pkg::REG_PITCH_MOUSE_GAIN:  prdata = DW'(cfg_reg.pitch_mouse_gain);
            gmrc_pkg::REG_HOME_TOLERANCE:    prdata = DW'(cfg_reg.home_tolerance);
            gmrc_pkg::REG_YAW_RETURN_GAIN:   prdata = DW'(cfg_reg.yaw_return_gain);
            gmrc_pkg::REG_PITCH_RETURN_GAIN: prdata = DW'(cfg_reg.pitch_return_gain);
            default:                         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/gmrc_mode_fsm.sv
// Gimbal mode state machine with init timeout and settle counters.
`default_nettype none

module gmrc_mode_fsm #(
    parameter int INIT_TIMEOUT_TICKS = gmrc_pkg::DEF_INIT_TIMEOUT_TICKS,
    parameter int SETTLE_TICKS       = gmrc_pkg::DEF_SETTLE_TICKS,
    parameter int HOME_YAW           = gmrc_pkg::DEF_HOME_YAW,
    parameter int HOME_PITCH         = gmrc_pkg::DEF_HOME_PITCH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                advance,
    input  wire logic                                link_offline,
    input  wire logic        [gmrc_pkg::SW_W-1:0]    mode_switch,
    input  wire logic signed [gmrc_pkg::ANGLE_W-1:0] yaw_angle,
    input  wire logic signed [gmrc_pkg::ANGLE_W-1:0] pitch_angle,
    input  wire logic        [gmrc_pkg::TOL_W-1:0]   home_tolerance,
    output logic signed      [gmrc_pkg::ERR_W-1:0]   yaw_err,
    output logic signed      [gmrc_pkg::ERR_W-1:0]   pitch_err,
    output gmrc_pkg::gmrc_sel_t                      sel
);

    localparam int AW = gmrc_pkg::ANGLE_W;
    localparam int EW = gmrc_pkg::ERR_W;
    localparam logic signed [AW-1:0] HOME_Y = HOME_YAW[AW-1:0];
    localparam logic signed [AW-1:0] HOME_P = HOME_PITCH[AW-1:0];
    localparam logic [gmrc_pkg::INIT_CNT_W-1:0] INIT_LIM =
        INIT_TIMEOUT_TICKS[gmrc_pkg::INIT_CNT_W-1:0];
    localparam logic [gmrc_pkg::SETTLE_CNT_W-1:0] SETTLE_LIM =
        SETTLE_TICKS[gmrc_pkg::SETTLE_CNT_W-1:0];

    logic [gmrc_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [gmrc_pkg::INIT_CNT_W-1:0]   init_ticks_reg, init_ticks_next;
    logic [gmrc_pkg::SETTLE_CNT_W-1:0] settle_ticks_reg, settle_ticks_next;
    logic                              recovering_reg, recovering_next;

    logic [EW-1:0] yaw_abs, pitch_abs, tol_x;
    logic          both_homed, pitch_in_tol;

    assign yaw_err   = EW'(HOME_Y) - EW'(yaw_angle);
    assign pitch_err = EW'(HOME_P) - EW'(pitch_angle);
    assign yaw_abs   = yaw_err[EW-1]   ? EW'(-yaw_err)   : EW'(yaw_err);
    assign pitch_abs = pitch_err[EW-1] ? EW'(-pitch_err) : EW'(pitch_err);
    assign tol_x     = EW'(home_tolerance);

    assign both_homed   = (yaw_abs < tol_x) && (pitch_abs < tol_x);
    assign pitch_in_tol = (pitch_abs <= tol_x);

    always_comb begin
        mode_next         = mode_reg;
        init_ticks_next   = init_ticks_reg;
        settle_ticks_next = settle_ticks_reg;
        recovering_next   = recovering_reg;
        unique case (mode_reg)
            gmrc_pkg::MODE_INIT: begin
                if (init_ticks_reg < INIT_LIM)
                    init_ticks_next = init_ticks_reg + 1'b1;
                if (both_homed && (settle_ticks_reg < SETTLE_LIM))
                    settle_ticks_next = settle_ticks_reg + 1'b1;
                if ((init_ticks_next >= INIT_LIM) || (settle_ticks_next >= SETTLE_LIM)) begin
                    init_ticks_next   = '0;
                    settle_ticks_next = '0;
                    mode_next         = gmrc_pkg::MODE_STOP;
                    recovering_next   = 1'b0;
                end
            end
            gmrc_pkg::MODE_RELAX: begin
                if (!link_offline) begin
                    mode_next       = gmrc_pkg::MODE_INIT;
                    recovering_next = 1'b1;
                end
            end
            // later tests override earlier ones
            gmrc_pkg::MODE_STOP: begin
                if (link_offline)                   mode_next = gmrc_pkg::MODE_RELAX;
                if (mode_switch == gmrc_pkg::SW_DOWN) mode_next = gmrc_pkg::MODE_GYRO;
                if (mode_switch == gmrc_pkg::SW_UP)   mode_next = gmrc_pkg::MODE_ENCODER;
            end
            gmrc_pkg::MODE_GYRO: begin
                if (link_offline)                   mode_next = gmrc_pkg::MODE_RELAX;
                if (mode_switch == gmrc_pkg::SW_MID)  mode_next = gmrc_pkg::MODE_STOP;
                if (mode_switch == gmrc_pkg::SW_UP)   mode_next = gmrc_pkg::MODE_ENCODER;
            end
            // offline takes priority here
            gmrc_pkg::MODE_ENCODER: begin
                if (link_offline)
                    mode_next = gmrc_pkg::MODE_RELAX;
                else if (mode_switch == gmrc_pkg::SW_MID)
                    mode_next = gmrc_pkg::MODE_STOP;
                else if (mode_switch == gmrc_pkg::SW_DOWN)
                    mode_next = gmrc_pkg::MODE_GYRO;
            end
            default: ;
        endcase
    end

    assign sel.mode       = mode_next;
    assign sel.manual     = (mode_next == gmrc_pkg::MODE_GYRO) ||
                            (mode_next == gmrc_pkg::MODE_ENCODER);
    assign sel.homing     = (mode_next == gmrc_pkg::MODE_INIT);
    assign sel.yaw_homing = recovering_next || pitch_in_tol;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= gmrc_pkg::MODE_INIT;
            init_ticks_reg   <= '0;
            settle_ticks_reg <= '0;
            recovering_reg   <= 1'b0;
        end else if (advance) begin
            mode_reg         <= mode_next;
            init_ticks_reg   <= init_ticks_next;
            settle_ticks_reg <= settle_ticks_next;
            recovering_reg   <= recovering_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gmrc_cmd_path.sv
// Increment datapath: gain products, add, floor and saturate into the result register.
`default_nettype none

module gmrc_cmd_path (
    input  wire logic                                aclk,
    input  wire logic                                out_load,
    input  wire gmrc_pkg::gmrc_cfg_t                 cfg,
    input  wire gmrc_pkg::gmrc_sel_t                 sel,
    input  wire logic signed [gmrc_pkg::STICK_W-1:0] yaw_stick,
    input  wire logic signed [gmrc_pkg::STICK_W-1:0] pitch_stick,
    input  wire logic signed [gmrc_pkg::MOUSE_W-1:0] mouse_x,
    input  wire logic signed [gmrc_pkg::MOUSE_W-1:0] mouse_y,
    input  wire logic signed [gmrc_pkg::ERR_W-1:0]   yaw_err,
    input  wire logic signed [gmrc_pkg::ERR_W-1:0]   pitch_err,
    output logic             [gmrc_pkg::MODE_W-1:0]  cmd_mode,
    output logic signed      [gmrc_pkg::INC_W-1:0]   yaw_increment,
    output logic signed      [gmrc_pkg::INC_W-1:0]   pitch_increment
);

    localparam int PW = gmrc_pkg::PROD_W;
    localparam int SW = gmrc_pkg::SUM_W;
    localparam int QW = gmrc_pkg::QUOT_W;
    localparam int IW = gmrc_pkg::INC_W;
    localparam int XW = gmrc_pkg::STICK_W + 1;

    logic signed [XW-1:0] ys_x, ps_x, db_x;
    logic signed [gmrc_pkg::STICK_W-1:0] ys_db, ps_db;

    logic signed [PW-1:0] yaw_a, yaw_b, pitch_a, pitch_b;

    logic signed [SW-1:0] yaw_sum, pitch_sum;
    logic signed [IW-1:0] yaw_sat, pitch_sat;

    logic [gmrc_pkg::MODE_W-1:0] out_mode_reg;
    logic signed [IW-1:0] out_yaw_reg, out_pitch_reg;

    function automatic logic signed [IW-1:0] sat_inc(input logic signed [SW-1:0] s);
        logic [QW-1:0] q;
        q = s[SW-1:gmrc_pkg::FRAC_W];   // arithmetic shift: floor
        if ((q[QW-1:IW-1] == '0) || (q[QW-1:IW-1] == '1))
            sat_inc = q[IW-1:0];
        else
            sat_inc = q[QW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    endfunction

    // dead band: magnitude at or below the band reads as zero
    assign ys_x  = XW'(yaw_stick);
    assign ps_x  = XW'(pitch_stick);
    assign db_x  = $signed(XW'(cfg.stick_deadband));
    assign ys_db = ((ys_x > db_x) || (ys_x < -db_x)) ? yaw_stick : '0;
    assign ps_db = ((ps_x > db_x) || (ps_x < -db_x)) ? pitch_stick : '0;

    always_comb begin
        yaw_a   = '0;
        yaw_b   = '0;
        pitch_a = '0;
        pitch_b = '0;
        if (sel.manual) begin
            yaw_a   = PW'(ys_db) * $signed(PW'(cfg.yaw_stick_gain));
            yaw_b   = PW'(-(PW'(mouse_x) * $signed(PW'(cfg.yaw_mouse_gain))));
            pitch_a = PW'(ps_db) * $signed(PW'(cfg.pitch_stick_gain));
            pitch_b = PW'(mouse_y) * $signed(PW'(cfg.pitch_mouse_gain));
        end else if (sel.homing) begin
            pitch_a = PW'(pitch_err) * $signed(PW'(cfg.pitch_return_gain));
            if (sel.yaw_homing)
                yaw_a = PW'(yaw_err) * $signed(PW'(cfg.yaw_return_gain));
        end
    end

    assign yaw_sum   = SW'(yaw_a) + SW'(yaw_b);
    assign pitch_sum = SW'(pitch_a) + SW'(pitch_b);
    assign yaw_sat   = sat_inc(yaw_sum);
    assign pitch_sat = sat_inc(pitch_sum);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_mode_reg  <= sel.mode;
            out_yaw_reg   <= yaw_sat;
            out_pitch_reg <= pitch_sat;
        end
    end

    assign cmd_mode        = out_mode_reg;
    assign yaw_increment   = out_yaw_reg;
    assign pitch_increment = out_pitch_reg;

endmodule

`default_nettype wire

FILE: rtl/gimbal_mode_and_rate_command.sv
// Top level of the gimbal mode and rate command block.
//
// One control tick in, one result out. Each input transaction first steps
// the gimbal mode (relax, init, stop, gyro, encoder) and then gives yaw and
// pitch angle increments in Q3.12 rad, saturated to 16 bits: stick and mouse
// rate in gyro and encoder, a proportional return to home in init (pitch
// alone until pitch is within tolerance, unless re-entered from relax), zero
// in relax and stop. The block takes one transaction per clock while the
// output is not held by m_tready. An accepted transaction sits in the input
// register; the mode update, the four gain multipliers, the add, floor shift
// and saturation form one combinational pass into the result register, which
// drives m_tvalid. The mode and init counters step as a transaction leaves
// the input register, so the following transaction is evaluated against the
// updated mode. Back-pressure on m_tready holds the result register and then
// the input register; a waiting result does not block a new input
// transaction while the input register is free. Registers are written over
// the APB-style port at byte address 4*index and should only change while
// the block is idle.
`default_nettype none

module gimbal_mode_and_rate_command #(
    parameter int INIT_TIMEOUT_TICKS = gmrc_pkg::DEF_INIT_TIMEOUT_TICKS,
    parameter int SETTLE_TICKS       = gmrc_pkg::DEF_SETTLE_TICKS,
    parameter int HOME_YAW           = gmrc_pkg::DEF_HOME_YAW,
    parameter int HOME_PITCH         = gmrc_pkg::DEF_HOME_PITCH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // s_tdata, lowest bit up: link_offline[0], mode_switch[2:1],
    // yaw_stick[13:3], pitch_stick[24:14], mouse_x[40:25], mouse_y[56:41],
    // yaw_angle[72:57], pitch_angle[88:73], zero[95:89]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [gmrc_pkg::S_TDATA_W-1:0]      s_tdata,

    // m_tdata, lowest bit up: mode[2:0], yaw_increment[18:3],
    // pitch_increment[34:19], zero[39:35]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [gmrc_pkg::M_TDATA_W-1:0]      m_tdata,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gmrc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [gmrc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [gmrc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int SWW = gmrc_pkg::SW_W;
    localparam int STW = gmrc_pkg::STICK_W;
    localparam int MW  = gmrc_pkg::MOUSE_W;
    localparam int AW  = gmrc_pkg::ANGLE_W;
    localparam int IW  = gmrc_pkg::INC_W;
    localparam int MDW = gmrc_pkg::MODE_W;

    // bit offsets inside s_tdata
    localparam int O_SW = 1;
    localparam int O_YS = O_SW + SWW;
    localparam int O_PS = O_YS + STW;
    localparam int O_MX = O_PS + STW;
    localparam int O_MY = O_MX + MW;
    localparam int O_YA = O_MY + MW;
    localparam int O_PA = O_YA + AW;
    localparam int IN_USED = O_PA + AW;
    localparam int OUT_USED = MDW + 2 * IW;

    gmrc_pkg::gmrc_cfg_t cfg;
    gmrc_pkg::gmrc_sel_t sel;

    // input register
    logic                   in_valid_reg;
    logic [IN_USED-1:0]     in_data_reg;

    logic                   out_valid_reg;
    logic                   out_load;

    logic                   link_offline;
    logic [SWW-1:0]         mode_switch;
    logic signed [STW-1:0]  yaw_stick, pitch_stick;
    logic signed [MW-1:0]   mouse_x, mouse_y;
    logic signed [AW-1:0]   yaw_angle, pitch_angle;
    logic signed [gmrc_pkg::ERR_W-1:0] yaw_err, pitch_err;

    logic [MDW-1:0]         cmd_mode;
    logic signed [IW-1:0]   yaw_increment, pitch_increment;

    // stage advance: a stage loads when it is empty or its contents move on
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (!out_valid_reg || m_tready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata[IN_USED-1:0];
    end

    // field unpack
    assign link_offline = in_data_reg[0];
    assign mode_switch  = in_data_reg[O_YS-1:O_SW];
    assign yaw_stick    = in_data_reg[O_PS-1:O_YS];
    assign pitch_stick  = in_data_reg[O_MX-1:O_PS];
    assign mouse_x      = in_data_reg[O_MY-1:O_MX];
    assign mouse_y      = in_data_reg[O_YA-1:O_MY];
    assign yaw_angle    = in_data_reg[O_PA-1:O_YA];
    assign pitch_angle  = in_data_reg[IN_USED-1:O_PA];

    gmrc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // mode state steps on the transaction leaving the input register
    gmrc_mode_fsm #(
        .INIT_TIMEOUT_TICKS (INIT_TIMEOUT_TICKS),
        .SETTLE_TICKS       (SETTLE_TICKS),
        .HOME_YAW           (HOME_YAW),
        .HOME_PITCH         (HOME_PITCH)
    ) u_fsm (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (out_load),
        .link_offline   (link_offline),
        .mode_switch    (mode_switch),
        .yaw_angle      (yaw_angle),
        .pitch_angle    (pitch_angle),
        .home_tolerance (cfg.home_tolerance),
        .yaw_err        (yaw_err),
        .pitch_err      (pitch_err),
        .sel            (sel)
    );

    gmrc_cmd_path u_path (
        .aclk            (aclk),
        .out_load        (out_load),
        .cfg             (cfg),
        .sel             (sel),
        .yaw_stick       (yaw_stick),
        .pitch_stick     (pitch_stick),
        .mouse_x         (mouse_x),
        .mouse_y         (mouse_y),
        .yaw_err         (yaw_err),
        .pitch_err       (pitch_err),
        .cmd_mode        (cmd_mode),
        .yaw_increment   (yaw_increment),
        .pitch_increment (pitch_increment)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gmrc_pkg::M_TDATA_W - OUT_USED){1'b0}},
                       pitch_increment, yaw_increment, cmd_mode};

endmodule

`default_nettype wire
